### design/dttp_pkg.sv
// Shared types, constants and helpers for the date/time text parser.
package dttp_pkg;

    localparam int unsigned NUM_FIELDS = 5;
    localparam int unsigned FLD_IDX_W  = 3;

    localparam logic [FLD_IDX_W-1:0] FLD_MONTH  = 3'd0;
    localparam logic [FLD_IDX_W-1:0] FLD_DAY    = 3'd1;
    localparam logic [FLD_IDX_W-1:0] FLD_YEAR   = 3'd2;
    localparam logic [FLD_IDX_W-1:0] FLD_HOUR   = 3'd3;
    localparam logic [FLD_IDX_W-1:0] FLD_MINUTE = 3'd4;

    localparam logic [15:0] MAG_MAX = 16'hFFFF;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FEW_FIELDS = 2'd1,
        ST_BAD_NUMBER = 2'd2,
        ST_BAD_DATE   = 2'd3
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_result;

    // Parsed tokens: magnitude, negative-nonzero flag, and leap flag of the year token
    typedef struct packed {
        logic [NUM_FIELDS-1:0][15:0] mag;
        logic [NUM_FIELDS-1:0]       neg;
        logic                        leap;
    } t_fields;

    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] days;
        unique case (month)
            4'd2:                      days = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

### design/dttp_in_if.sv
// Character input channel: valid/ready with one character and an end-of-text flag.
interface dttp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

### design/dttp_out_if.sv
// Result channel: valid/ready with status and the stored date.
interface dttp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;

    modport source (output valid, output status, output year, output month, output day,
                    output hour, output minute, input ready);
    modport sink   (input valid, input status, input year, input month, input day,
                    input hour, input minute, output ready);
endinterface

### design/date_time_text_parser.sv
// Top level of the date/time text parser: input register, parse stage, result register.
// The last character is held in the input register, its result in the result register.
// Throughput: one character per cycle; the parse stage stalls only when a result
// is due and the result register is still full.
// Reset (synchronous, active low) empties both registers, opens an empty first
// token and zeroes the stored date.
module date_time_text_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dttp_in_if.sink         i_in,
    dttp_out_if.source      o_out
);

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_last;

    logic              r_out_valid;
    dttp_pkg::t_result r_out;

    logic              out_free;
    logic              s_go;
    logic              step;
    logic              res_valid;
    dttp_pkg::t_result res;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s_go       = !r_in_last || out_free;
    assign step       = r_in_valid && s_go;
    assign i_in.ready = !r_in_valid || s_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_ch   <= i_in.ch;
            r_in_last <= i_in.last;
        end
    end

    dttp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ch        (r_in_ch),
        .i_last      (r_in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out.status;
    assign o_out.year   = r_out.year;
    assign o_out.month  = r_out.month;
    assign o_out.day    = r_out.day;
    assign o_out.hour   = r_out.hour;
    assign o_out.minute = r_out.minute;

`ifndef ASSERT_OFF
    // a new result only follows a beat that ended a text
    a_res_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !$past(o_out.valid)) |-> $past(r_in_valid && r_in_last))
        else $error("result appeared without a last character");

    // a held input beat is not overwritten
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s_go) |=> (r_in_valid && $stable(r_in_ch) && $stable(r_in_last)))
        else $error("stalled input beat lost");

    // an ok status always carries an in-range date
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == dttp_pkg::ST_OK)) |->
        ((o_out.month >= 4'd1) && (o_out.month <= 4'd12) && (o_out.day >= 5'd1)
         && (o_out.hour <= 5'd23) && (o_out.minute <= 6'd59)))
        else $error("ok status with out-of-range date");
`endif

endmodule

### design/dttp_date_check.sv
// Calendar range check of five parsed fields.
module dttp_date_check (
    input  dttp_pkg::t_fields i_fld,
    output logic              o_ok
);

    logic [15:0] mo;
    logic [15:0] dd;
    logic [15:0] hh;
    logic [15:0] mi;
    logic [4:0]  lim;

    assign mo  = i_fld.mag[dttp_pkg::FLD_MONTH];
    assign dd  = i_fld.mag[dttp_pkg::FLD_DAY];
    assign hh  = i_fld.mag[dttp_pkg::FLD_HOUR];
    assign mi  = i_fld.mag[dttp_pkg::FLD_MINUTE];
    assign lim = dttp_pkg::days_in_month(mo[3:0], i_fld.leap);

    assign o_ok = !(|i_fld.neg)
                && (mo >= 16'd1) && (mo <= 16'd12)
                && (dd >= 16'd1) && (dd <= {11'd0, lim})
                && (hh <= 16'd23) && (mi <= 16'd59);

endmodule

### design/dttp_parse.sv
// Tokenizer state, field capture and end-of-text status for one character per cycle while i_step is high.
module dttp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    output logic              o_res_valid,
    output dttp_pkg::t_result o_res
);

    // token state
    logic [dttp_pkg::FLD_IDX_W-1:0] r_tok_idx;
    logic        r_in_tok;
    logic        r_tok_chars;
    logic        r_tok_neg;
    logic        r_tok_digit;
    logic        r_tok_err;
    logic [15:0] r_acc;
    logic [3:0]  r_tens;
    logic [3:0]  r_ones;
    logic [1:0]  r_h4;
    logic        r_num_err;
    dttp_pkg::t_fields r_fld;

    logic [15:0] r_st_year;
    logic [3:0]  r_st_month;
    logic [4:0]  r_st_day;
    logic [4:0]  r_st_hour;
    logic [5:0]  r_st_minute;

    logic        is_sep;
    logic        is_digit;
    logic        is_sign;
    logic [3:0]  dig;

    logic        b_chars, b_neg, b_digit, b_err;
    logic [15:0] b_acc;
    logic [3:0]  b_tens, b_ones;
    logic [1:0]  b_h4;

    logic        p_neg, p_digit, p_err;
    logic [15:0] p_acc;
    logic [3:0]  p_tens, p_ones;
    logic [1:0]  p_h4;
    logic [19:0] acc_mul;

    logic        c_neg, c_digit, c_err;
    logic [15:0] c_acc;
    logic [3:0]  c_tens, c_ones;
    logic [1:0]  c_h4;
    logic [1:0]  c_mod4;
    logic        c_leap;

    logic        close_req;
    logic        do_close;
    dttp_pkg::t_fields n_fld;
    logic        n_num_err;
    logic [dttp_pkg::FLD_IDX_W-1:0] n_tok_idx;
    logic        date_ok;
    dttp_pkg::t_status status;

    assign is_sep   = (i_ch == dttp_pkg::CH_SPACE) || (i_ch == dttp_pkg::CH_COLON);
    assign is_digit = (i_ch >= dttp_pkg::CH_ZERO) && (i_ch <= dttp_pkg::CH_NINE);
    assign is_sign  = (i_ch == dttp_pkg::CH_PLUS) || (i_ch == dttp_pkg::CH_MINUS);
    assign dig      = i_ch[3:0];

    // A character after a separator opens a fresh token
    assign b_chars = r_in_tok & r_tok_chars;
    assign b_neg   = r_in_tok & r_tok_neg;
    assign b_digit = r_in_tok & r_tok_digit;
    assign b_err   = r_in_tok & r_tok_err;
    assign b_acc   = r_in_tok ? r_acc  : 16'd0;
    assign b_tens  = r_in_tok ? r_tens : 4'd0;
    assign b_ones  = r_in_tok ? r_ones : 4'd0;
    assign b_h4    = r_in_tok ? r_h4   : 2'd0;

    assign acc_mul = ({4'd0, b_acc} << 3) + ({4'd0, b_acc} << 1) + {16'd0, dig};

    always_comb begin
        p_neg   = b_neg;
        p_digit = b_digit;
        p_err   = b_err;
        p_acc   = b_acc;
        p_tens  = b_tens;
        p_ones  = b_ones;
        p_h4    = b_h4;
        if (is_digit) begin
            if (acc_mul > {4'd0, dttp_pkg::MAG_MAX}) begin
                p_acc = dttp_pkg::MAG_MAX;
                p_err = 1'b1;
            end else begin
                p_acc = acc_mul[15:0];
            end
            p_digit = 1'b1;
            // last two decimal digits and (value / 100) mod 4, for the leap test
            p_tens  = b_ones;
            p_ones  = dig;
            p_h4    = {b_h4[0], 1'b0} + b_tens[1:0];
        end else if (!b_chars && is_sign) begin
            p_neg = (i_ch == dttp_pkg::CH_MINUS);
        end else begin
            p_err = 1'b1;
        end
    end

    // A separator closes the token as it stood; the last character closes it after update
    assign c_neg   = is_sep ? r_tok_neg   : p_neg;
    assign c_digit = is_sep ? r_tok_digit : p_digit;
    assign c_err   = is_sep ? r_tok_err   : p_err;
    assign c_acc   = is_sep ? r_acc       : p_acc;
    assign c_tens  = is_sep ? r_tens      : p_tens;
    assign c_ones  = is_sep ? r_ones      : p_ones;
    assign c_h4    = is_sep ? r_h4        : p_h4;

    assign c_mod4 = {c_tens[0], 1'b0} + c_ones[1:0];
    assign c_leap = (c_mod4 == 2'd0)
                  && (!((c_tens == 4'd0) && (c_ones == 4'd0)) || (c_h4 == 2'd0));

    assign close_req = is_sep ? r_in_tok : i_last;
    assign do_close  = close_req
                     && (r_tok_idx < dttp_pkg::FLD_IDX_W'(dttp_pkg::NUM_FIELDS));

    always_comb begin
        n_fld     = r_fld;
        n_num_err = r_num_err;
        n_tok_idx = r_tok_idx;
        if (do_close) begin
            n_fld.mag[r_tok_idx] = c_acc;
            n_fld.neg[r_tok_idx] = c_neg && (c_acc != 16'd0);
            if (r_tok_idx == dttp_pkg::FLD_YEAR) begin
                n_fld.leap = c_leap;
            end
            n_num_err = r_num_err | c_err | !c_digit;
            n_tok_idx = r_tok_idx + 1'b1;
        end
    end

    dttp_date_check u_date_check (
        .i_fld (n_fld),
        .o_ok  (date_ok)
    );

    always_comb begin
        if (n_tok_idx < dttp_pkg::FLD_IDX_W'(dttp_pkg::NUM_FIELDS)) begin
            status = dttp_pkg::ST_FEW_FIELDS;
        end else if (n_num_err) begin
            status = dttp_pkg::ST_BAD_NUMBER;
        end else if (!date_ok) begin
            status = dttp_pkg::ST_BAD_DATE;
        end else begin
            status = dttp_pkg::ST_OK;
        end
    end

    always_comb begin
        o_res.status = status;
        if (status == dttp_pkg::ST_OK) begin
            o_res.year   = n_fld.mag[dttp_pkg::FLD_YEAR];
            o_res.month  = n_fld.mag[dttp_pkg::FLD_MONTH][3:0];
            o_res.day    = n_fld.mag[dttp_pkg::FLD_DAY][4:0];
            o_res.hour   = n_fld.mag[dttp_pkg::FLD_HOUR][4:0];
            o_res.minute = n_fld.mag[dttp_pkg::FLD_MINUTE][5:0];
        end else begin
            o_res.year   = r_st_year;
            o_res.month  = r_st_month;
            o_res.day    = r_st_day;
            o_res.hour   = r_st_hour;
            o_res.minute = r_st_minute;
        end
    end

    assign o_res_valid = i_step && i_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_idx   <= '0;
            r_in_tok    <= 1'b1;
            r_tok_chars <= 1'b0;
            r_tok_neg   <= 1'b0;
            r_tok_digit <= 1'b0;
            r_tok_err   <= 1'b0;
            r_acc       <= '0;
            r_tens      <= '0;
            r_ones      <= '0;
            r_h4        <= '0;
            r_num_err   <= 1'b0;
            r_st_year   <= '0;
            r_st_month  <= '0;
            r_st_day    <= '0;
            r_st_hour   <= '0;
            r_st_minute <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_tok_idx   <= '0;
                r_in_tok    <= 1'b1;
                r_tok_chars <= 1'b0;
                r_tok_neg   <= 1'b0;
                r_tok_digit <= 1'b0;
                r_tok_err   <= 1'b0;
                r_acc       <= '0;
                r_tens      <= '0;
                r_ones      <= '0;
                r_h4        <= '0;
                r_num_err   <= 1'b0;
                r_st_year   <= o_res.year;
                r_st_month  <= o_res.month;
                r_st_day    <= o_res.day;
                r_st_hour   <= o_res.hour;
                r_st_minute <= o_res.minute;
            end else if (is_sep) begin
                r_in_tok  <= 1'b0;
                r_tok_idx <= n_tok_idx;
                r_num_err <= n_num_err;
            end else begin
                r_in_tok    <= 1'b1;
                r_tok_chars <= 1'b1;
                r_tok_neg   <= p_neg;
                r_tok_digit <= p_digit;
                r_tok_err   <= p_err;
                r_acc       <= p_acc;
                r_tens      <= p_tens;
                r_ones      <= p_ones;
                r_h4        <= p_h4;
            end
        end
    end

    // captured fields are only read once all five are written in the same text
    always_ff @(posedge i_clk) begin
        if (i_step && !i_last && is_sep) begin
            r_fld <= n_fld;
        end
    end

endmodule
